// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, codes and defaults for the text console writer blocks.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFFS_W = 11;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SETCUR = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BS,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_CLEAR,
    OP_SETCUR,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_BLANK,
    BK_RESP
  } back_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFFS_W-1:0] cursor_offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
    logic              rejected;
  } out_item_t;

  typedef struct packed {
    op_e               kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
    logic              in_range;
  } op_t;

endpackage

// ----- hw/rtl/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input transfers, decodes the command and control bytes and checks
// the target position before the operation enters the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int Columns = tcw_pkg::COLUMNS_DEF,
  parameter int Rows    = tcw_pkg::ROWS_DEF
) (
  input  logic             in_valid_i,
  input  tcw_pkg::in_item_t in_item_i,
  input  logic             space_i,
  output logic             in_ready_o,
  output logic             push_o,
  output tcw_pkg::op_t     op_o
);

  tcw_pkg::op_e kind;

  always_comb begin
    unique case (tcw_pkg::cmd_e'(in_item_i.command))
      tcw_pkg::CMD_PUT: begin
        unique case (in_item_i.char_code)
          tcw_pkg::CH_BS:  kind = tcw_pkg::OP_BS;
          tcw_pkg::CH_TAB: kind = tcw_pkg::OP_TAB;
          tcw_pkg::CH_LF:  kind = tcw_pkg::OP_NL;
          tcw_pkg::CH_CR:  kind = tcw_pkg::OP_CR;
          default:         kind = tcw_pkg::OP_PRINT;
        endcase
      end
      tcw_pkg::CMD_CLEAR:  kind = tcw_pkg::OP_CLEAR;
      tcw_pkg::CMD_SETCUR: kind = tcw_pkg::OP_SETCUR;
      default:             kind = tcw_pkg::OP_READ;
    endcase
  end

  assign op_o.kind       = kind;
  assign op_o.char_code  = in_item_i.char_code;
  assign op_o.target_col = in_item_i.target_col;
  assign op_o.target_row = in_item_i.target_row;
  assign op_o.in_range   = (in_item_i.target_col < tcw_pkg::COL_W'(Columns)) &&
                           (in_item_i.target_row < tcw_pkg::ROW_W'(Rows));

  assign in_ready_o = space_i;
  assign push_o     = in_valid_i && space_i;

endmodule

// ----- hw/rtl/tcw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer operation queue
// A short first-in first-out buffer of decoded operations between the front
// end and the execution unit.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  tcw_pkg::op_t op_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output tcw_pkg::op_t head_o
);

  localparam logic [tcw_pkg::QPTR_W-1:0] PtrLast = tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1);

  tcw_pkg::op_t                slot_q [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tcw_pkg::QPTR_W:0]    count_q, count_d;

  assign full_o  = (count_q == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer execution unit
// Holds the screen memory, the cursor, the attribute register and the result
// register. Rows are kept in a ring, so a scroll moves the top row pointer
// and blanks one row instead of copying the screen.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int Columns = tcw_pkg::COLUMNS_DEF,
  parameter int Rows    = tcw_pkg::ROWS_DEF,
  parameter int TabStep = tcw_pkg::TAB_STEP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i,
  input  logic                       q_empty_i,
  input  tcw_pkg::op_t               head_i,
  output logic                       pop_o,
  output logic                       init_busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tcw_pkg::out_item_t         out_item_o
);

  localparam int CellCount = Rows * Columns;
  localparam int AddrW     = $clog2(CellCount);
  localparam int CW        = tcw_pkg::COL_W;
  localparam int RW        = tcw_pkg::ROW_W;

  localparam logic [AddrW-1:0] SweepLast = AddrW'(CellCount - 1);
  localparam logic [CW-1:0]    ColLast   = CW'(Columns - 1);
  localparam logic [RW-1:0]    RowLast   = RW'(Rows - 1);

  logic [tcw_pkg::CELL_W-1:0] mem [CellCount];

  tcw_pkg::back_state_e       state_q, state_d;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [RW-1:0]              top_q, top_d;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic [AddrW-1:0]           sweep_q, sweep_d;
  logic [CW-1:0]              bcol_q, bcol_d;
  logic [RW-1:0]              brow_q, brow_d;
  logic                       scrolled_q, scrolled_d;
  logic                       rejected_q, rejected_d;
  logic                       rdhit_q, rdhit_d;
  logic                       clr_pend_q, clr_pend_d;
  logic                       out_valid_q, out_valid_d;
  tcw_pkg::out_item_t         out_q, out_d;
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  logic                       pop;
  logic [CW:0]                adv_w;
  logic                       adv_wrap;
  logic [CW-1:0]              adv_col;
  logic [CW-1:0]              bs_col;
  logic [RW-1:0]              bs_row;
  logic                       bs_do;
  logic                       line_inc;
  logic [RW-1:0]              lrow, prow;
  logic [CW-1:0]              acol;
  logic [RW:0]                psum;
  logic [AddrW-1:0]           cell_addr;
  logic                       wr_en, rd_en;
  logic [AddrW-1:0]           wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic [RW+CW-1:0]           offs_full;

  assign pop         = (state_q == tcw_pkg::BK_IDLE) && !q_empty_i && !out_valid_q;
  assign pop_o       = pop;
  assign init_busy_o = (state_q == tcw_pkg::BK_SWEEP) && !clr_pend_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Cursor movement for put operations.
  always_comb begin
    if (head_i.kind == tcw_pkg::OP_TAB) begin
      adv_w = (CW + 1)'(col_q) + (CW + 1)'(TabStep);
    end else begin
      adv_w = (CW + 1)'(col_q) + 1'b1;
    end
    adv_wrap = (adv_w >= (CW + 1)'(Columns));
    adv_col  = adv_wrap ? CW'(adv_w - (CW + 1)'(Columns)) : CW'(adv_w);
    bs_do    = 1'b1;
    bs_col   = col_q;
    bs_row   = row_q;
    if (col_q != '0) begin
      bs_col = col_q - 1'b1;
    end else if (row_q != '0) begin
      bs_col = ColLast;
      bs_row = row_q - 1'b1;
    end else begin
      bs_do = 1'b0;
    end
  end

  // Screen address: logical row through the row ring, then row times width.
  always_comb begin
    if (head_i.kind == tcw_pkg::OP_READ) begin
      lrow = head_i.target_row;
      acol = head_i.target_col;
    end else if (head_i.kind == tcw_pkg::OP_BS) begin
      lrow = bs_row;
      acol = bs_col;
    end else begin
      lrow = row_q;
      acol = col_q;
    end
    psum = (RW + 1)'(lrow) + (RW + 1)'(top_q);
    if (psum >= (RW + 1)'(Rows)) begin
      prow = RW'(psum - (RW + 1)'(Rows));
    end else begin
      prow = RW'(psum);
    end
    if (state_q == tcw_pkg::BK_BLANK) begin
      prow = brow_q;
      acol = bcol_q;
    end
    cell_addr = AddrW'(prow) * AddrW'(Columns) + AddrW'(acol);
  end

  assign line_inc = ((head_i.kind == tcw_pkg::OP_PRINT || head_i.kind == tcw_pkg::OP_TAB) &&
                     adv_wrap) || (head_i.kind == tcw_pkg::OP_NL);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::BK_SWEEP: begin
        if (sweep_q == SweepLast) begin
          state_d = clr_pend_q ? tcw_pkg::BK_RESP : tcw_pkg::BK_IDLE;
        end
      end
      tcw_pkg::BK_IDLE: begin
        if (pop) begin
          if (head_i.kind == tcw_pkg::OP_CLEAR) begin
            state_d = tcw_pkg::BK_SWEEP;
          end else if (line_inc && row_q == RowLast) begin
            state_d = tcw_pkg::BK_BLANK;
          end else begin
            state_d = tcw_pkg::BK_RESP;
          end
        end
      end
      tcw_pkg::BK_BLANK: begin
        if (bcol_q == ColLast) begin
          state_d = tcw_pkg::BK_RESP;
        end
      end
      default: begin
        state_d = tcw_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    top_d       = top_q;
    sweep_d     = sweep_q;
    bcol_d      = bcol_q;
    brow_d      = brow_q;
    scrolled_d  = scrolled_q;
    rejected_d  = rejected_q;
    rdhit_d     = rdhit_q;
    clr_pend_d  = clr_pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = cell_addr;
    wr_data     = tcw_pkg::BLANK_CELL;
    rd_en       = 1'b0;
    offs_full   = (RW + CW)'(row_q) * (RW + CW)'(Columns) + (RW + CW)'(col_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tcw_pkg::BK_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        sweep_d = (sweep_q == SweepLast) ? '0 : sweep_q + 1'b1;
      end
      tcw_pkg::BK_IDLE: begin
        if (pop) begin
          scrolled_d = 1'b0;
          rejected_d = 1'b0;
          rdhit_d    = 1'b0;
          clr_pend_d = 1'b0;
          unique case (head_i.kind)
            tcw_pkg::OP_PRINT: begin
              wr_en   = 1'b1;
              wr_data = {attr_q, head_i.char_code};
              col_d   = adv_col;
            end
            tcw_pkg::OP_TAB: begin
              col_d = adv_col;
            end
            tcw_pkg::OP_NL: begin
              col_d = '0;
            end
            tcw_pkg::OP_CR: begin
              col_d = '0;
            end
            tcw_pkg::OP_BS: begin
              wr_en = bs_do;
              col_d = bs_col;
              row_d = bs_row;
            end
            tcw_pkg::OP_CLEAR: begin
              col_d      = '0;
              row_d      = '0;
              top_d      = '0;
              clr_pend_d = 1'b1;
            end
            tcw_pkg::OP_SETCUR: begin
              if (head_i.in_range) begin
                col_d = head_i.target_col;
                row_d = head_i.target_row;
              end else begin
                rejected_d = 1'b1;
              end
            end
            default: begin
              rd_en   = head_i.in_range;
              rdhit_d = head_i.in_range;
            end
          endcase
          if (line_inc) begin
            if (row_q == RowLast) begin
              // The old top row becomes the new bottom row and is blanked.
              top_d      = (top_q == RowLast) ? '0 : top_q + 1'b1;
              brow_d     = top_q;
              bcol_d     = '0;
              scrolled_d = 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end
        end
      end
      tcw_pkg::BK_BLANK: begin
        wr_en  = 1'b1;
        bcol_d = bcol_q + 1'b1;
      end
      default: begin
        out_valid_d         = 1'b1;
        out_d.cursor_col    = col_q;
        out_d.cursor_row    = row_q;
        out_d.cursor_offset = tcw_pkg::OFFS_W'(offs_full);
        out_d.cell_data     = rdhit_q ? rdata_q : '0;
        out_d.scrolled      = scrolled_q;
        out_d.rejected      = rejected_q;
        clr_pend_d          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::BK_SWEEP;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      attr_q      <= tcw_pkg::ATTR_RESET;
      sweep_q     <= '0;
      bcol_q      <= '0;
      brow_q      <= '0;
      scrolled_q  <= 1'b0;
      rejected_q  <= 1'b0;
      rdhit_q     <= 1'b0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      top_q       <= top_d;
      sweep_q     <= sweep_d;
      bcol_q      <= bcol_d;
      brow_q      <= brow_d;
      scrolled_q  <= scrolled_d;
      rejected_q  <= rejected_d;
      rdhit_q     <= rdhit_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[cell_addr];
    end
  end

endmodule

// ----- hw/rtl/text_console_writer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine with a screen memory, a cursor and scrolling.
// ----------------------------------------------------------------------------
// After reset the block blanks the whole screen memory, one cell per cycle;
// no input transfer is taken during that pass. Afterwards a put, set cursor
// or read command is executed when it is popped from the queue head, and its
// result is registered in the result state; the next command is popped
// only once that result has been taken. A put that scrolls first blanks the
// new bottom row, and a clear screen command blanks the whole screen memory
// again before its result. A four-entry queue lets input transfers continue
// while a command executes or a result waits.
module text_console_writer_top #(
  parameter int Columns = tcw_pkg::COLUMNS_DEF,
  parameter int Rows    = tcw_pkg::ROWS_DEF,
  parameter int TabStep = tcw_pkg::TAB_STEP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tcw_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tcw_pkg::out_item_t         out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i
);

  logic         push, pop, q_full, q_empty, init_busy;
  tcw_pkg::op_t push_op, head_op;

  assign cfg_ready_o = 1'b1;

  tcw_front #(
    .Columns(Columns),
    .Rows   (Rows)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .space_i   (!q_full && !init_busy),
    .in_ready_o(in_ready_o),
    .push_o    (push),
    .op_o      (push_op)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (head_op)
  );

  tcw_back #(
    .Columns(Columns),
    .Rows   (Rows),
    .TabStep(TabStep)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .head_i     (head_op),
    .pop_o      (pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- hw/rtl/tcw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer port checker
// Checks result transfers seen on the top-level ports.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int Columns = tcw_pkg::COLUMNS_DEF,
  parameter int Rows    = tcw_pkg::ROWS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input tcw_pkg::out_item_t out_item_i
);

  localparam int SumW = tcw_pkg::ROW_W + tcw_pkg::COL_W;

  logic [SumW-1:0] offs_chk;

  assign offs_chk = SumW'(out_item_i.cursor_row) * SumW'(Columns) +
                    SumW'(out_item_i.cursor_col);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.cursor_col < tcw_pkg::COL_W'(Columns) &&
                    out_item_i.cursor_row < tcw_pkg::ROW_W'(Rows))
    else $error("cursor outside the screen");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.cursor_offset == tcw_pkg::OFFS_W'(offs_chk))
    else $error("cursor offset does not match the cursor position");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.scrolled |->
      out_item_i.cursor_row == tcw_pkg::ROW_W'(Rows - 1) && !out_item_i.rejected)
    else $error("scroll did not leave the cursor on the bottom row");

endmodule

bind text_console_writer_top tcw_checker #(
  .Columns(Columns),
  .Rows   (Rows)
) u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_i (out_item_o)
);

// ----- sim/text_console_writer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the command, result and attribute channels of the console engine.
// It keeps its own screen, cursor and attribute, works out the result of
// every accepted command and compares each accepted result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module text_console_writer_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  tcw_pkg::in_item_t          in_item_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  tcw_pkg::out_item_t         out_item_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i,
  output int                         pending_o,
  output int                         errors_o
);

  localparam int Cols  = tcw_pkg::COLUMNS_DEF;
  localparam int Rows  = tcw_pkg::ROWS_DEF;
  localparam int Tab   = tcw_pkg::TAB_STEP_DEF;
  localparam int Cells = Rows * Cols;
  localparam int CellW = tcw_pkg::CELL_W;

  logic [CellW-1:0]           screen [Cells];
  int                         cur_col;
  int                         cur_row;
  logic [tcw_pkg::ATTR_W-1:0] attr;
  tcw_pkg::out_item_t         console_results_q [$];
  int                         mismatches = 0;

  function automatic void blank_screen();
    int k;
    for (k = 0; k < Cells; k++) screen[k] = tcw_pkg::BLANK_CELL;
  endfunction

  function automatic void check_field(string name, logic [CellW-1:0] exp_v,
                                      logic [CellW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic tcw_pkg::out_item_t apply_console_command(tcw_pkg::in_item_t item);
    tcw_pkg::out_item_t res;
    int                 k;
    logic               on_screen;
    res = '0;
    on_screen = (int'(item.target_col) < Cols) && (int'(item.target_row) < Rows);
    case (item.command)
      tcw_pkg::CMD_PUT: begin
        case (item.char_code)
          tcw_pkg::CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
              screen[cur_row * Cols + cur_col] = tcw_pkg::BLANK_CELL;
            end else if (cur_row > 0) begin
              cur_row--;
              cur_col = Cols - 1;
              screen[cur_row * Cols + cur_col] = tcw_pkg::BLANK_CELL;
            end
          end
          tcw_pkg::CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          tcw_pkg::CH_CR: cur_col = 0;
          tcw_pkg::CH_TAB: cur_col += Tab;
          default: begin
            screen[cur_row * Cols + cur_col] = {attr, item.char_code};
            cur_col++;
          end
        endcase
        if (cur_col >= Cols) begin
          cur_col -= Cols;
          cur_row++;
        end
        if (cur_row >= Rows) begin
          for (k = 0; k < Cells - Cols; k++) screen[k] = screen[k + Cols];
          for (k = Cells - Cols; k < Cells; k++) screen[k] = tcw_pkg::BLANK_CELL;
          cur_row = Rows - 1;
          res.scrolled = 1'b1;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::CMD_SETCUR: begin
        if (on_screen) begin
          cur_col = int'(item.target_col);
          cur_row = int'(item.target_row);
        end else begin
          res.rejected = 1'b1;
        end
      end
      tcw_pkg::CMD_READ: begin
        if (on_screen) begin
          res.cell_data = screen[int'(item.target_row) * Cols + int'(item.target_col)];
        end
      end
      default: ;
    endcase
    res.cursor_col    = tcw_pkg::COL_W'(cur_col);
    res.cursor_row    = tcw_pkg::ROW_W'(cur_row);
    res.cursor_offset = tcw_pkg::OFFS_W'(cur_row * Cols + cur_col);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tcw_pkg::out_item_t want;
    if (!rst_ni) begin
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      attr = tcw_pkg::ATTR_RESET;
      console_results_q.delete();
      pending_o <= 0;
      errors_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) attr = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (console_results_q.size() == 0) begin
          $error("unexpected result transfer: cursor_col 0x%0h, cursor_row 0x%0h",
                 out_item_i.cursor_col, out_item_i.cursor_row);
          mismatches++;
        end else begin
          want = console_results_q.pop_front();
          check_field("cursor_col", CellW'(want.cursor_col),
                      CellW'(out_item_i.cursor_col));
          check_field("cursor_row", CellW'(want.cursor_row),
                      CellW'(out_item_i.cursor_row));
          check_field("cursor_offset", CellW'(want.cursor_offset),
                      CellW'(out_item_i.cursor_offset));
          check_field("cell_data", want.cell_data, out_item_i.cell_data);
          check_field("scrolled", CellW'(want.scrolled), CellW'(out_item_i.scrolled));
          check_field("rejected", CellW'(want.rejected), CellW'(out_item_i.rejected));
        end
      end
      if (in_valid_i && in_ready_i) begin
        console_results_q.push_back(apply_console_command(in_item_i));
      end
      pending_o <= console_results_q.size();
      errors_o <= mismatches;
    end
  end

endmodule

// ----- sim/tb_text_console_writer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives commands and attribute writes into the console engine with random
// command gaps and result stalls, a long receiver hold-off and a stretch at
// full rate. A directed set of commands comes first, then random command
// mixes under several attribute settings. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 200;
  localparam int CycleLimit   = 1_000_000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  tcw_pkg::in_item_t          in_item;
  logic                       out_valid;
  logic                       out_ready;
  tcw_pkg::out_item_t         out_item;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [tcw_pkg::ATTR_W-1:0] cfg_data;
  int                         pending;
  int                         errors;
  int                         idle_pct;
  int                         hold_count;

  text_console_writer_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  text_console_writer_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_text_console_writer_top: errors");
    $finish;
  end

  initial begin : result_receiver
    int seen;
    int k;
    seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_count != seen) begin
        seen = hold_count;
        out_ready <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic tcw_pkg::in_item_t make_item(tcw_pkg::cmd_e cmd,
                                                  logic [tcw_pkg::CHAR_W-1:0] ch,
                                                  logic [tcw_pkg::COL_W-1:0] col,
                                                  logic [tcw_pkg::ROW_W-1:0] row);
    tcw_pkg::in_item_t it;
    it.command    = cmd;
    it.char_code  = ch;
    it.target_col = col;
    it.target_row = row;
    return it;
  endfunction

  function automatic tcw_pkg::in_item_t random_command();
    tcw_pkg::in_item_t it;
    int                pick;
    it.command    = tcw_pkg::CMD_PUT;
    it.char_code  = tcw_pkg::CHAR_W'($urandom);
    it.target_col = tcw_pkg::COL_W'($urandom);
    it.target_row = tcw_pkg::ROW_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::CHAR_W'($urandom_range(126, 32));
    end else if (pick < 55) begin
      it.command = tcw_pkg::CMD_PUT;
    end else if (pick < 62) begin
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::CH_LF;
    end else if (pick < 67) begin
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::CH_CR;
    end else if (pick < 72) begin
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::CH_BS;
    end else if (pick < 77) begin
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::CH_TAB;
    end else if (pick < 85) begin
      it.command = tcw_pkg::CMD_SETCUR;
      if ($urandom_range(99) < 85) begin
        it.target_col = tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS_DEF - 1));
        it.target_row = $urandom_range(1)
                        ? tcw_pkg::ROW_W'(tcw_pkg::ROWS_DEF - 1)
                        : tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS_DEF - 1));
      end
    end else if (pick < 99) begin
      it.command = tcw_pkg::CMD_READ;
      if ($urandom_range(99) < 80) begin
        it.target_col = tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS_DEF - 1));
        it.target_row = tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS_DEF - 1));
      end
    end else begin
      it.command = tcw_pkg::CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic send_item(input tcw_pkg::in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_attr(input logic [tcw_pkg::ATTR_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    idle_pct   = 30;
    hold_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_attr(8'h1F);
    send_item(make_item(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, 8'h41, 7'd127, 5'd31));
    send_item(make_item(tcw_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, 8'h7F, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_READ, 8'h00, 7'd1, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_READ, 8'h00, 7'd3, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd79, 5'd24));
    send_item(make_item(tcw_pkg::CMD_PUT, 8'h5A, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd23));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd0, 5'd5));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd80, 5'd0));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd0, 5'd25));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(tcw_pkg::CMD_READ, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd75, 5'd3));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_SETCUR, 8'h00, 7'd10, 5'd24));
    send_item(make_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 7'd0, 5'd0));
    send_item(make_item(tcw_pkg::CMD_CLEAR, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd24));
    wait_idle();

    write_attr(8'h00);
    for (i = 0; i < 320; i++) begin
      if (i == 120) hold_count <= hold_count + 1;
      send_item(random_command());
    end
    wait_idle();

    write_attr(8'hFF);
    for (i = 0; i < 320; i++) begin
      if (i == 0) idle_pct <= 0;
      if (i == 150) idle_pct <= 30;
      send_item(random_command());
    end
    wait_idle();

    write_attr(tcw_pkg::ATTR_W'($urandom));
    for (i = 0; i < 60; i++) send_item(random_command());
    wait_idle();

    if (errors == 0) $display("tb_text_console_writer_top: clean");
    else $display("tb_text_console_writer_top: errors");
    $finish;
  end

endmodule

// ----- text_console_writer_top.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
hw/rtl/tcw_checker.sv
sim/text_console_writer_checker.sv
sim/tb_text_console_writer_top.sv
